// ===== design/pnq_pkg.sv =====
`timescale 1ns / 1ps
package pnq_pkg;

   // input item actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_QUANT = 2'd1;
   localparam logic [1:0] ACT_FILL  = 2'd2;

   localparam int ACTION_W  = 2;
   localparam int INDEX_W   = 8;
   localparam int COLOR_W   = 32;
   localparam int RGB_W     = 24;
   localparam int CHAN_W    = 8;
   localparam int SQ_W      = 16;
   localparam int DIST_W    = 18;
   localparam int ROOT_W    = 9;
   localparam int REM_W     = 12;
   localparam int ROOT_CNT_W = 4;
   localparam int REQ_DATA_W = 48;

   // larger than any squared rgb distance, so the first entry always wins
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic wr_entry;
      logic load_query;
      logic addr_clear;
      logic fill_step;
      logic scan_issue;
      logic flush;
      logic root_start;
      logic restart;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic issue_end;
      logic hit;
      logic scan_done;
      logic root_done;
      logic best_last;
      logic out_busy;
   } stat_type;

   // rgb332 index expanded to rgb888, bits repeated down each channel
   function automatic logic [RGB_W-1:0] rgb332_expand(input logic [INDEX_W-1:0] i);
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      r = {i[7:5], i[7:5], i[7:6]};
      g = {i[4:2], i[4:2], i[4:3]};
      b = {4{i[1:0]}};
      return {r, g, b};
   endfunction

endpackage

// ===== design/pnq_ram.sv =====
`timescale 1ns / 1ps
module pnq_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pnq_sqrt.sv =====
`timescale 1ns / 1ps
module pnq_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pnq_pkg::DIST_W-1:0] radicand,
   output logic                       done,
   output logic [pnq_pkg::DIST_W-1:0] root_sq
);
   import pnq_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIST_W-1:0]     rad_ff, rad_in;
   logic [DIST_W-1:0]     orig_ff, orig_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [REM_W-1:0]      rem_shift;
   logic [REM_W-1:0]      trial;

   // one root bit per cycle, two radicand bits brought down each step
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[DIST_W-1:DIST_W-2]};
   assign trial     = REM_W'({root_ff, 2'b01});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      orig_in = orig_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         orig_in = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[DIST_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ROOT_CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      orig_ff <= orig_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   // root squared is the radicand less the final remainder
   assign done    = done_ff;
   assign root_sq = orig_ff - DIST_W'(rem_ff);

endmodule

// ===== design/pnq_ctrl.sv =====
`timescale 1ns / 1ps
module pnq_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pnq_pkg::ACTION_W-1:0] action,
   input  pnq_pkg::stat_type          stat,
   output pnq_pkg::cmd_type           cmd
);
   import pnq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (action)
                  ACT_WRITE: begin
                     cmd.wr_entry = 1'b1;
                  end
                  ACT_QUANT: begin
                     cmd.load_query = 1'b1;
                     cmd.addr_clear = 1'b1;
                     cmd.flush      = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  ACT_FILL: begin
                     cmd.addr_clear = 1'b1;
                     state_in       = ST_FILL;
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (stat.hit) begin
               cmd.flush      = 1'b1;
               cmd.root_start = 1'b1;
               state_in       = ST_ROOT;
            end else begin
               cmd.scan_issue = !stat.issue_end;
               if (stat.scan_done) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROOT: begin
            if (stat.root_done) begin
               if (stat.best_last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.restart = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/pnq_datapath.sv =====
`timescale 1ns / 1ps
module pnq_datapath #(
   parameter int ENTRIES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pnq_pkg::cmd_type            cmd,
   output pnq_pkg::stat_type           stat,
   input  logic [pnq_pkg::INDEX_W-1:0] entry_index,
   input  logic [pnq_pkg::COLOR_W-1:0] color,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pnq_pkg::INDEX_W-1:0] nearest_index
);
   import pnq_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // palette addressing and entry valid bits (an entry never written reads as black)
   logic [IDX_W-1:0]   addr_ff, addr_in;
   logic               issue_end_ff, issue_end_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [RGB_W-1:0]   ram_wdata;
   logic [RGB_W-1:0]   ram_rdata;
   logic               wr_in_range;

   // query color
   logic [RGB_W-1:0]   query_ff;

   // read stage
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_ent_ff;

   // square stage
   logic               sq_vld_ff;
   logic [IDX_W-1:0]   sq_idx_ff;
   logic [SQ_W-1:0]    sq_r_ff, sq_g_ff, sq_b_ff;

   // sum stage
   logic               sum_vld_ff;
   logic [IDX_W-1:0]   sum_idx_ff;
   logic [DIST_W-1:0]  sum_ff;

   // best so far
   logic [IDX_W-1:0]   best_idx_ff;
   logic [DIST_W-1:0]  thresh_ff;

   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_data_ff;

   logic               root_done;
   logic [DIST_W-1:0]  root_sq;

   logic [RGB_W-1:0]   ent;
   logic [CHAN_W-1:0]  dr, dg, db;

   assign wr_in_range = ({1'b0, entry_index} < (INDEX_W + 1)'(ENTRIES));

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = rgb332_expand(INDEX_W'(addr_ff));
      valid_in  = valid_ff;
      if (cmd.wr_entry && wr_in_range) begin
         ram_we    = 1'b1;
         ram_waddr = entry_index[IDX_W-1:0];
         ram_wdata = color[RGB_W-1:0];
         valid_in[entry_index[IDX_W-1:0]] = 1'b1;
      end else if (cmd.fill_step) begin
         ram_we            = 1'b1;
         valid_in[addr_ff] = 1'b1;
      end
   end

   always_comb begin
      addr_in      = addr_ff;
      issue_end_in = issue_end_ff;
      if (cmd.addr_clear) begin
         addr_in      = '0;
         issue_end_in = 1'b0;
      end else if (cmd.restart) begin
         addr_in      = best_idx_ff + 1'b1;
         issue_end_in = 1'b0;
      end else if (cmd.fill_step || cmd.scan_issue) begin
         addr_in = addr_ff + 1'b1;
         if (cmd.scan_issue && addr_ff == LAST_IDX) begin
            issue_end_in = 1'b1;
         end
      end
   end

   pnq_ram #(
      .WIDTH (RGB_W),
      .DEPTH (ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   // absolute channel differences
   always_comb begin
      ent = rd_ent_ff ? ram_rdata : '0;
      dr  = (ent[23:16] > query_ff[23:16]) ? ent[23:16] - query_ff[23:16]
                                           : query_ff[23:16] - ent[23:16];
      dg  = (ent[15:8] > query_ff[15:8]) ? ent[15:8] - query_ff[15:8]
                                         : query_ff[15:8] - ent[15:8];
      db  = (ent[7:0] > query_ff[7:0]) ? ent[7:0] - query_ff[7:0]
                                       : query_ff[7:0] - ent[7:0];
   end

   pnq_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (sum_ff),
      .done     (root_done),
      .root_sq  (root_sq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         issue_end_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         sum_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         issue_end_ff <= issue_end_in;
         if (cmd.flush) begin
            rd_vld_ff  <= 1'b0;
            sq_vld_ff  <= 1'b0;
            sum_vld_ff <= 1'b0;
         end else begin
            rd_vld_ff  <= cmd.scan_issue;
            sq_vld_ff  <= rd_vld_ff;
            sum_vld_ff <= sq_vld_ff;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      addr_ff    <= addr_in;
      rd_idx_ff  <= addr_ff;
      rd_ent_ff  <= valid_ff[addr_ff];
      sq_idx_ff  <= rd_idx_ff;
      sq_r_ff    <= SQ_W'(dr) * SQ_W'(dr);
      sq_g_ff    <= SQ_W'(dg) * SQ_W'(dg);
      sq_b_ff    <= SQ_W'(db) * SQ_W'(db);
      sum_idx_ff <= sq_idx_ff;
      sum_ff     <= DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);
      if (cmd.load_query) begin
         query_ff  <= color[RGB_W-1:0];
         thresh_ff <= DIST_MAX;
      end else if (root_done) begin
         thresh_ff <= root_sq;
      end
      if (cmd.root_start) begin
         best_idx_ff <= sum_idx_ff;
      end
      if (cmd.emit) begin
         rsp_data_ff <= INDEX_W'(best_idx_ff);
      end
   end

   // floor(sqrt(d)) < k exactly when d < k*k
   always_comb begin
      stat           = '0;
      stat.fill_last = (addr_ff == LAST_IDX);
      stat.issue_end = issue_end_ff;
      stat.hit       = sum_vld_ff && (sum_ff < thresh_ff);
      stat.scan_done = sum_vld_ff && (sum_idx_ff == LAST_IDX) && !(sum_ff < thresh_ff);
      stat.root_done = root_done;
      stat.best_last = (best_idx_ff == LAST_IDX);
      stat.out_busy  = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign nearest_index = rsp_data_ff;

endmodule

// ===== design/palette_nearest_color_quantizer_top.sv =====
`timescale 1ns / 1ps
// nearest-color palette quantizer. holds a palette of ENTRIES rgb colors (alpha is
// dropped on write, it never affects a result) and runs one action per transaction:
// write one entry, fill the palette with the rgb332 expansion of each index, or
// quantize a query color, which returns the index of the first entry whose floored
// euclidean rgb distance is strictly the smallest. only quantize returns a
// transaction. after reset every entry reads as black. one item is handled at a
// time; during a quantize, entry 0 is always a new best entry. the scan streams
// the palette memory at one entry per cycle, except while a new best entry is
// resolved, through a three-stage distance pipeline; each new best entry drops that
// pipeline, runs a 9-step iterative square root that sets the new distance
// threshold, and restarts the scan at the entry after the best. a finished result
// sits in an output register, so the next item is taken while it waits; a later
// quantize result holds at its end until that register frees up.
module palette_nearest_color_quantizer_top #(
   parameter int ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] action, [9:2] entry_index, [41:10] color, [47:42] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] nearest_index
   output logic [7:0]  rsp_tdata
);
   import pnq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   logic [ACTION_W-1:0] req_action;
   logic [INDEX_W-1:0]  req_entry_index;
   logic [COLOR_W-1:0]  req_color;

   // unpack the request transaction
   assign req_action      = req_tdata[1:0];
   assign req_entry_index = req_tdata[9:2];
   assign req_color       = req_tdata[41:10];

   // sequencer: decodes actions, steps fill and scan, waits on the root unit
   pnq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   // palette memory, distance pipeline, best tracking and result register
   pnq_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .entry_index   (req_entry_index),
      .color         (req_color),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .nearest_index (rsp_tdata)
   );

endmodule
